[rtl/izhikevich_neuron_euler_step_defines.svh]
// Assertion macros shared by the neuron step RTL.
`ifndef IZHIKEVICH_NEURON_EULER_STEP_DEFINES_SVH
`define IZHIKEVICH_NEURON_EULER_STEP_DEFINES_SVH

// Check a condition at every clock edge outside reset.
`define IZN_ASSERT_NOW(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that a trigger is followed by a condition in the next cycle.
`define IZN_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) else $error(msg);

`endif

[rtl/izn_pkg.sv]
// Shared types, constants and helpers for the neuron step block.
`default_nettype none
package izn_pkg;

  // Shared multiplier widths and fixed-point shift
  localparam int MulW   = 33;
  localparam int ProdW  = 2 * MulW;
  localparam int AccW   = 48;
  localparam int QShift = 16;

  // Model constants, Q16.16
  localparam logic signed [31:0] K_POINT04       = 32'sd2621;
  localparam logic signed [31:0] K_140           = 32'sd9175040;
  localparam logic signed [31:0] U_RESTART       = -32'sd917504;
  localparam logic signed [31:0] V_RESET_DEFAULT = -32'sd4259840;

  // Register reset values
  localparam logic signed [31:0] RATE_A_RST = 32'sd1311;
  localparam logic signed [31:0] SENS_B_RST = 32'sd13107;
  localparam logic signed [31:0] JUMP_D_RST = 32'sd524288;
  localparam logic signed [31:0] PEAK_H_RST = 32'sd1966080;
  localparam logic [30:0]        STEP_DT_RST = 31'd6554;

  // Register indexes
  localparam int RegIdxW = 3;
  localparam logic [RegIdxW-1:0] REG_RATE_A  = 3'd0;
  localparam logic [RegIdxW-1:0] REG_SENS_B  = 3'd1;
  localparam logic [RegIdxW-1:0] REG_RESET_V = 3'd2;
  localparam logic [RegIdxW-1:0] REG_JUMP_D  = 3'd3;
  localparam logic [RegIdxW-1:0] REG_PEAK_H  = 3'd4;
  localparam logic [RegIdxW-1:0] REG_STEP_DT = 3'd5;

  typedef struct packed {
    logic signed [31:0] rate_a;
    logic signed [31:0] sensitivity_b;
    logic signed [31:0] reset_voltage;
    logic signed [31:0] recovery_jump;
    logic signed [31:0] peak_voltage;
    logic [30:0]        step_dt;
  } cfg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_VV,
    S_MUL_H,
    S_MUL_L,
    S_MUL_BV,
    S_INNER,
    S_MUL_AI,
    S_DV,
    S_MUL_DTV,
    S_MUL_DTU,
    S_UPD_U,
    S_EMIT1,
    S_JUMP,
    S_EMIT2
  } state_t;

  // Clamp a wide signed value to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    if (x > 64'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (x < -64'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return signed'(x[31:0]);
    end
  endfunction

endpackage
`default_nettype wire

[rtl/izhikevich_neuron_euler_step.sv]
// Top level of the Izhikevich neuron forward Euler step block.
//
//  channel  direction  handshake              payload
//  input    in         in_valid / in_ready    current, restart
//  output   out        out_valid / out_ready  membrane, recovery, spike, last
//  config   in         APB psel / penable     paddr, pwdata, prdata
//
// A request is accepted in the idle state and its first row is loaded after 7 passes
// through the shared 33x33 multiplier between add and saturate steps; the next
// request is taken only once the sequencer is back in idle, after a spike also
// after its reset row. The dependent multiplier chain holds one request at a time.
// Reset (rst, synchronous) loads v = -65.0, u = -14.0 and the register defaults.
// A stalled output holds the sequencer at a row state; a last row may wait alone.
`default_nettype none
module izhikevich_neuron_euler_step
  import izn_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [31:0] current,
  input  wire logic               restart,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      membrane,
  output logic signed [31:0]      recovery,
  output logic                    spike,
  output logic                    last,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [4:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  cfg_t                    cfg;
  logic signed [MulW-1:0]  mul_a, mul_b;
  logic signed [ProdW-1:0] p;

  izn_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  izn_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (p)
  );

  izn_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .current   (current),
    .restart   (restart),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .membrane  (membrane),
    .recovery  (recovery),
    .spike     (spike),
    .last      (last),
    .mul_a     (mul_a),
    .mul_b     (mul_b),
    .p         (p)
  );

endmodule
`default_nettype wire

[rtl/izn_mul.sv]
// Shared signed multiplier with a registered product.
`default_nettype none
module izn_mul
  import izn_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic signed [MulW-1:0]  a,
  input  wire logic signed [MulW-1:0]  b,
  output logic signed [ProdW-1:0]      p
);

  // Register the full product every cycle
  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule
`default_nettype wire

[rtl/izn_regs.sv]
// APB configuration registers for the neuron step block.
`default_nettype none
module izn_regs
  import izn_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output cfg_t             cfg
);

  logic                wr_en;
  logic [RegIdxW-1:0]  idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = paddr[4:2];

  // Write registers on the access cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rate_a        <= RATE_A_RST;
      cfg.sensitivity_b <= SENS_B_RST;
      cfg.reset_voltage <= V_RESET_DEFAULT;
      cfg.recovery_jump <= JUMP_D_RST;
      cfg.peak_voltage  <= PEAK_H_RST;
      cfg.step_dt       <= STEP_DT_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_RATE_A:  cfg.rate_a        <= signed'(pwdata);
        REG_SENS_B:  cfg.sensitivity_b <= signed'(pwdata);
        REG_RESET_V: cfg.reset_voltage <= signed'(pwdata);
        REG_JUMP_D:  cfg.recovery_jump <= signed'(pwdata);
        REG_PEAK_H:  cfg.peak_voltage  <= signed'(pwdata);
        REG_STEP_DT: cfg.step_dt       <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  // Return the addressed register
  always_comb begin
    unique case (idx)
      REG_RATE_A:  prdata = cfg.rate_a;
      REG_SENS_B:  prdata = cfg.sensitivity_b;
      REG_RESET_V: prdata = cfg.reset_voltage;
      REG_JUMP_D:  prdata = cfg.recovery_jump;
      REG_PEAK_H:  prdata = cfg.peak_voltage;
      REG_STEP_DT: prdata = {1'b0, cfg.step_dt};
      default:     prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

[rtl/izn_core.sv]
// Sequencer and datapath of one Euler step over the shared multiplier.
`default_nettype none
`include "izhikevich_neuron_euler_step_defines.svh"
module izn_core
  import izn_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire cfg_t               cfg,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [31:0] current,
  input  wire logic               restart,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      membrane,
  output logic signed [31:0]      recovery,
  output logic                    spike,
  output logic                    last,
  output logic signed [MulW-1:0]  mul_a,
  output logic signed [MulW-1:0]  mul_b,
  input  wire logic signed [ProdW-1:0] p
);

  state_t state, state_next;

  logic signed [31:0]      v, u, cur, inner, dv, du;
  logic [15:0]             lo;
  logic signed [AccW-1:0]  acc;
  logic signed [AccW-1:0]  v_ext;
  logic signed [ProdW-1:0] p_shift;
  logic signed [63:0]      p_sh64;
  logic                    accept, out_free, out_load, hit;
  logic                    peak_row, peak_load;

  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign p_shift  = p >>> QShift;
  assign p_sh64   = signed'(p_shift[63:0]);
  assign v_ext    = AccW'(v);
  assign hit      = (v >= cfg.peak_voltage);

  // Advance the sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:    if (accept) state_next = S_MUL_VV;
      S_MUL_VV:  state_next = S_MUL_H;
      S_MUL_H:   state_next = S_MUL_L;
      S_MUL_L:   state_next = S_MUL_BV;
      S_MUL_BV:  state_next = S_INNER;
      S_INNER:   state_next = S_MUL_AI;
      S_MUL_AI:  state_next = S_DV;
      S_DV:      state_next = S_MUL_DTV;
      S_MUL_DTV: state_next = S_MUL_DTU;
      S_MUL_DTU: state_next = S_UPD_U;
      S_UPD_U:   state_next = S_EMIT1;
      S_EMIT1: begin
        if (out_free) state_next = hit ? S_JUMP : S_IDLE;
      end
      S_JUMP:    state_next = S_EMIT2;
      S_EMIT2: begin
        if (out_free) state_next = S_IDLE;
      end
      default:   state_next = S_IDLE;
    endcase
  end

  // Outputs: multiplier operands, handshake and row load
  always_comb begin
    mul_a    = '0;
    mul_b    = '0;
    in_ready = 1'b0;
    out_load = 1'b0;
    unique case (state)
      S_IDLE:    in_ready = 1'b1;
      S_MUL_VV: begin
        mul_a = MulW'(v);
        mul_b = MulW'(v);
      end
      S_MUL_H: begin
        mul_a = signed'({2'b00, p[62:32]});
        mul_b = MulW'(K_POINT04);
      end
      S_MUL_L: begin
        mul_a = signed'({17'b0, lo});
        mul_b = MulW'(K_POINT04);
      end
      S_MUL_BV: begin
        mul_a = MulW'(cfg.sensitivity_b);
        mul_b = MulW'(v);
      end
      S_MUL_AI: begin
        mul_a = MulW'(cfg.rate_a);
        mul_b = MulW'(inner);
      end
      S_MUL_DTV: begin
        mul_a = signed'({2'b00, cfg.step_dt});
        mul_b = MulW'(dv);
      end
      S_MUL_DTU: begin
        mul_a = signed'({2'b00, cfg.step_dt});
        mul_b = MulW'(du);
      end
      S_EMIT1, S_EMIT2: out_load = out_free;
      default: ;
    endcase
  end

  // Hold membrane and recovery state
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= V_RESET_DEFAULT;
      u <= U_RESTART;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept && restart) begin
            v <= cfg.reset_voltage;
            u <= U_RESTART;
          end
        end
        S_MUL_DTU: v <= sat32(64'(v) + p_sh64);
        S_UPD_U:   u <= sat32(64'(u) + p_sh64);
        S_JUMP: begin
          v <= cfg.reset_voltage;
          u <= sat32(64'(u) + 64'(cfg.recovery_jump));
        end
        default: ;
      endcase
    end
  end

  // Build the derivative terms step by step
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE:   if (accept) cur <= current;
      S_MUL_H:  lo <= p[31:16];
      S_MUL_L:  acc <= signed'(p[AccW-1:0]);
      S_MUL_BV: acc <= acc + signed'(p_shift[AccW-1:0]);
      S_INNER: begin
        inner <= sat32(p_sh64 - 64'(u));
        acc   <= acc + (v_ext <<< 2) + v_ext;
      end
      S_MUL_AI: acc <= acc + AccW'(cur) - AccW'(u);
      S_DV: begin
        du <= sat32(p_sh64);
        dv <= sat32(64'(acc) + 64'(K_140));
      end
      default: ;
    endcase
  end

  // Load result rows into the output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      if (state == S_EMIT1 && hit) begin
        membrane <= cfg.peak_voltage;
        spike    <= 1'b1;
        last     <= 1'b0;
      end else begin
        membrane <= v;
        spike    <= 1'b0;
        last     <= 1'b1;
      end
      recovery <= u;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign peak_row  = out_valid && spike;
  assign peak_load = out_load && state == S_EMIT1 && hit;

  // A pending peak row keeps the input closed
  `IZN_ASSERT_NOW(a_spike_blocks_input, !(peak_row && in_ready), "input open on peak row")
  // A peak row is always followed by the reset step
  `IZN_ASSERT_NEXT(a_spike_then_jump, peak_load, state == S_JUMP && spike, "peak row without reset step")
  // The peak row carries the threshold value
  `IZN_ASSERT_NOW(a_peak_value, !peak_row || membrane == cfg.peak_voltage, "peak row value wrong")
  // An accepted request starts the sequence
  `IZN_ASSERT_NEXT(a_accept_starts, accept, state == S_MUL_VV, "request did not start step")

endmodule
`default_nettype wire

[verif/izn_checker.sv]
// Row predictor and scoreboard for the neuron step block, fed by the channel and register traffic.
`timescale 1ns / 100ps
module izn_checker
  import izn_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [31:0] current,
  input  logic               restart,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] membrane,
  input  logic signed [31:0] recovery,
  input  logic               spike,
  input  logic               last,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output int                 fail_count,
  output int                 pending,
  output int                 rows_seen,
  output int                 spikes_seen
);

  localparam longint S32_MAX  = 64'sd2147483647;
  localparam longint S32_MIN  = -64'sd2147483648;
  localparam longint POINT04  = 64'sd2621;
  localparam longint DRIVE140 = 64'sd140 * 64'sd65536;
  localparam logic signed [31:0] U_AFTER_RESTART = -32'sd917504;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic signed [31:0] membrane;
    logic signed [31:0] recovery;
    logic               spike;
    logic               last;
  } neuron_row_t;

  neuron_row_t        rows_due[$];
  cfg_t               regs;
  logic signed [31:0] v_now;
  logic signed [31:0] u_now;

  // Clamp to the signed 32-bit range
  function automatic logic signed [31:0] clamp_s32(input longint x);
    if (x > S32_MAX) begin
      return 32'sh7FFFFFFF;
    end else if (x < S32_MIN) begin
      return 32'sh80000000;
    end
    return x[31:0];
  endfunction

  // Drop the fraction of a Q32.32 product, rounding toward minus infinity
  function automatic longint drop_frac(input longint x);
    return x >>> 16;
  endfunction

  // Append a row to those due
  task automatic queue_row(input neuron_row_t r);
    rows_due = {rows_due, r};
  endtask

  // Advance the neuron by one Euler step and queue the rows it emits
  task automatic advance_neuron(input logic signed [31:0] i_app, input logic reload);
    longint             v;
    longint             u;
    longint             dt;
    longint             vsq;
    longint             inner;
    logic signed [31:0] dv;
    logic signed [31:0] du;
    logic signed [31:0] nv;
    logic signed [31:0] nu;
    if (reload) begin
      v_now = regs.reset_voltage;
      u_now = U_AFTER_RESTART;
    end
    v   = v_now;
    u   = u_now;
    dt  = longint'(regs.step_dt);
    vsq = drop_frac(v * v);
    dv  = clamp_s32(drop_frac(vsq * POINT04) + 5 * v + DRIVE140 - u + longint'(i_app));
    inner = drop_frac(longint'(regs.sensitivity_b) * v) - u;
    du  = clamp_s32(drop_frac(longint'(regs.rate_a) * longint'(clamp_s32(inner))));
    nv  = clamp_s32(v + drop_frac(dt * longint'(dv)));
    nu  = clamp_s32(u + drop_frac(dt * longint'(du)));
    if (nv >= regs.peak_voltage) begin
      // peak row first, then the row after the reset jump
      queue_row('{regs.peak_voltage, nu, 1'b1, 1'b0});
      v_now = regs.reset_voltage;
      u_now = clamp_s32(longint'(nu) + longint'(regs.recovery_jump));
      queue_row('{v_now, u_now, 1'b0, 1'b1});
    end else begin
      v_now = nv;
      u_now = nu;
      queue_row('{nv, nu, 1'b0, 1'b1});
    end
  endtask

  // Count a failure and report the first few
  task automatic flag_row(input string what, input neuron_row_t want);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) begin
      $display("%0t %s (want/got): membrane %0d/%0d recovery %0d/%0d",
               $time, what, want.membrane, membrane, want.recovery, recovery);
      $display("  spike %0b/%0b last %0b/%0b", want.spike, spike, want.last, last);
    end
  endtask

  always @(posedge clk) begin
    neuron_row_t want;
    if (rst) begin
      // Hold the register defaults, the resting state and the counts
      regs.rate_a        = RATE_A_RST;
      regs.sensitivity_b = SENS_B_RST;
      regs.reset_voltage = V_RESET_DEFAULT;
      regs.recovery_jump = JUMP_D_RST;
      regs.peak_voltage  = PEAK_H_RST;
      regs.step_dt       = STEP_DT_RST;
      v_now = V_RESET_DEFAULT;
      u_now = U_AFTER_RESTART;
      rows_due.delete();
      fail_count  = 0;
      rows_seen   = 0;
      spikes_seen = 0;
    end else begin
      // Track register writes
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_RATE_A:  regs.rate_a        = pwdata;
          REG_SENS_B:  regs.sensitivity_b = pwdata;
          REG_RESET_V: regs.reset_voltage = pwdata;
          REG_JUMP_D:  regs.recovery_jump = pwdata;
          REG_PEAK_H:  regs.peak_voltage  = pwdata;
          REG_STEP_DT: regs.step_dt       = pwdata[30:0];
          default: ;
        endcase
      end
      // Compare each delivered row with the oldest one due
      if (out_valid && out_ready) begin
        rows_seen++;
        if (spike) begin
          spikes_seen++;
        end
        if (rows_due.size() == 0) begin
          flag_row("row with none due", '0);
        end else begin
          want = rows_due.pop_front();
          if (membrane !== want.membrane || recovery !== want.recovery ||
              spike !== want.spike || last !== want.last) begin
            flag_row("row mismatch", want);
          end
        end
      end
      // Predict the rows of each accepted request
      if (in_valid && in_ready) begin
        advance_neuron(current, restart);
      end
    end
    pending = rows_due.size();
  end

endmodule

[verif/tb.sv]
// Top-level testbench: stimulus, register settings, flow control and verdict for the neuron step.
`timescale 1ns / 100ps
module tb
  import izn_pkg::*;
();

  localparam int Q_ONE      = 65536;
  localparam int LONG_HOLD  = 300;
  localparam int IDLE_LIMIT = 5000;
  localparam int N_DIRECTED = 8;

  typedef enum int {
    PH_DEFAULT,
    PH_EXT_HIGH,
    PH_EXT_LOW,
    PH_CHATTER,
    PH_INVERTED,
    PH_NEGATIVE,
    PH_TUNED_A,
    PH_TUNED_B,
    PH_TUNED_C,
    PH_WILD,
    PH_COUNT
  } phase_t;

  typedef struct packed {
    logic signed [31:0] cur;
    logic               reload;
  } stim_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [31:0] current = '0;
  logic               restart = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] membrane;
  logic signed [31:0] recovery;
  logic               spike;
  logic               last;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [4:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  int fail_count;
  int pending;
  int rows_seen;
  int spikes_seen;
  int requests_sent = 0;
  int burst_left = 0;
  int idle_cycles = 0;
  logic long_hold_req = 1'b0;
  logic long_hold_done = 1'b0;

  always #1 clk = ~clk;

  izhikevich_neuron_euler_step dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .current(current), .restart(restart),
    .out_valid(out_valid), .out_ready(out_ready), .membrane(membrane),
    .recovery(recovery), .spike(spike), .last(last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  izn_checker scoreboard (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .current(current), .restart(restart),
    .out_valid(out_valid), .out_ready(out_ready), .membrane(membrane),
    .recovery(recovery), .spike(spike), .last(last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .fail_count(fail_count), .pending(pending),
    .rows_seen(rows_seen), .spikes_seen(spikes_seen)
  );

  // Abort when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no progress for %0d cycles, %0d rows outstanding",
               idle_cycles, pending);
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Row sink: stall in windows of varying pressure, with one long hold-off on request
  initial begin : row_sink
    int window_left;
    int ready_pct;
    window_left = 0;
    ready_pct   = 100;
    forever begin
      @(negedge clk);
      if (long_hold_req && !long_hold_done) begin
        long_hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end
      if (window_left == 0) begin
        window_left = $urandom_range(8, 64);
        case ($urandom_range(4))
          0, 1: ready_pct = 100;
          2:    ready_pct = 80;
          3:    ready_pct = 50;
          default: ready_pct = 15;
        endcase
      end
      window_left--;
      out_ready <= ($urandom_range(99) < ready_pct);
    end
  end

  // Write one register through the APB port; leave the bus selected
  task automatic write_reg(input logic [RegIdxW-1:0] idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
  endtask

  // Load a full register setting while the block is idle
  task automatic load_setting(input cfg_t s);
    write_reg(REG_RATE_A, s.rate_a);
    write_reg(REG_SENS_B, s.sensitivity_b);
    write_reg(REG_RESET_V, s.reset_voltage);
    write_reg(REG_JUMP_D, s.recovery_jump);
    write_reg(REG_PEAK_H, s.peak_voltage);
    write_reg(REG_STEP_DT, {1'b0, s.step_dt});
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // Offer one request and wait for it to be taken; insert gaps between bursts
  task automatic offer(input stim_t s);
    int gap;
    in_valid <= 1'b1;
    current  <= s.cur;
    restart  <= s.reload;
    do @(posedge clk); while (!in_ready);
    requests_sent++;
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  // Stop offering and wait for every due row
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  function automatic stim_t directed_stim(input int k);
    case (k)
      0:       return '{32'sd0, 1'b1};
      1:       return '{32'sd10 * Q_ONE, 1'b0};
      2:       return '{32'sh7FFFFFFF, 1'b0};
      3:       return '{32'sh80000000, 1'b0};
      4:       return '{32'sh7FFFFFFF, 1'b1};
      5:       return '{-32'sd1, 1'b0};
      6:       return '{32'sd1, 1'b0};
      default: return '{32'sh80000000, 1'b1};
    endcase
  endfunction

  // Mostly a drive level near the current one, with wide and extreme values mixed in
  function automatic logic signed [31:0] pick_current(input int level);
    int sel;
    sel = $urandom_range(99);
    if (sel < 70) begin
      return level + int'($urandom_range(0, 4 * Q_ONE)) - 2 * Q_ONE;
    end else if (sel < 85) begin
      return int'($urandom_range(0, 60 * Q_ONE)) - 10 * Q_ONE;
    end else if (sel < 95) begin
      return $urandom;
    end
    case ($urandom_range(3))
      0:       return 32'sh7FFFFFFF;
      1:       return 32'sh80000000;
      2:       return 32'sd0;
      default: return -32'sd1;
    endcase
  endfunction

  function automatic cfg_t make_setting(input phase_t ph);
    cfg_t s;
    s = '{RATE_A_RST, SENS_B_RST, V_RESET_DEFAULT, JUMP_D_RST, PEAK_H_RST, STEP_DT_RST};
    case (ph)
      PH_EXT_HIGH: s = '{32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000,
                         32'sh7FFFFFFF, 32'sh7FFFFFFF, 31'h7FFFFFFF};
      PH_EXT_LOW:  s = '{32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                         32'sh80000000, 32'sh80000000, 31'd0};
      PH_CHATTER:  s = '{32'sd1311, 32'sd13107, -32'sd50 * Q_ONE,
                         32'sd2 * Q_ONE, 32'sd30 * Q_ONE, 31'(Q_ONE / 2)};
      PH_INVERTED: s = '{32'sd1311, 32'sd13107, 32'sd40 * Q_ONE,
                         32'sd8 * Q_ONE, 32'sd30 * Q_ONE, 31'(Q_ONE / 4)};
      PH_NEGATIVE: s = '{-32'sd1311, -32'sd13107, -32'sd65 * Q_ONE,
                         32'sd8 * Q_ONE, 32'sd30 * Q_ONE, 31'(Q_ONE)};
      PH_TUNED_A, PH_TUNED_B, PH_TUNED_C: begin
        s.rate_a        = $urandom_range(1) ? 1311 : 6554;
        s.sensitivity_b = $urandom_range(1) ? 13107 : 16384;
        s.reset_voltage = -int'($urandom_range(50, 65)) * Q_ONE;
        s.recovery_jump = int'($urandom_range(1, 8)) * Q_ONE;
        s.peak_voltage  = 30 * Q_ONE;
        s.step_dt       = 31'(Q_ONE >> $urandom_range(0, 3));
      end
      PH_WILD: s = '{$urandom, $urandom, $urandom, $urandom, $urandom, 31'($urandom)};
      default: ;
    endcase
    return s;
  endfunction

  function automatic int random_count(input phase_t ph);
    case (ph)
      PH_DEFAULT, PH_CHATTER:  return 150;
      PH_EXT_HIGH, PH_EXT_LOW: return 40;
      PH_INVERTED, PH_WILD:    return 60;
      PH_NEGATIVE:             return 80;
      default:                 return 100;
    endcase
  endfunction

  initial begin : stimulus
    phase_t ph;
    int     n;
    int     level;
    stim_t  s;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    level = 10 * Q_ONE;
    for (int p = 0; p < PH_COUNT; p++) begin
      ph = phase_t'(p);
      load_setting(make_setting(ph));
      // Directed requests under the default and both extreme settings
      if (ph == PH_DEFAULT || ph == PH_EXT_HIGH || ph == PH_EXT_LOW) begin
        for (int k = 0; k < N_DIRECTED; k++) begin
          offer(directed_stim(k));
        end
      end
      if (ph == PH_CHATTER) begin
        long_hold_req <= 1'b1;
      end
      n = random_count(ph);
      for (int k = 0; k < n; k++) begin
        if (k == n / 2) begin
          drain();
        end
        if ($urandom_range(15) == 0) begin
          level = int'($urandom_range(0, 40)) * Q_ONE;
        end
        s.cur    = pick_current(level);
        s.reload = ($urandom_range(39) == 0);
        offer(s);
      end
      drain();
    end
    repeat (40) @(negedge clk);
    $display("summary: %0d requests over %0d register settings, %0d rows checked, %0d spikes",
             requests_sent, PH_COUNT, rows_seen, spikes_seen);
    if (pending != 0) begin
      $display("summary: %0d rows never delivered", pending);
    end
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
